// ===== sv/pidsc_pkg.sv =====
// Package for the PID steering controller: register indexes, reset values,
// field widths and sequencer codes. Depends on nothing.
`default_nettype none
package pidsc_pkg;

	localparam int POS_W   = 16;
	localparam int ERR_W   = 17;
	localparam int DIFF_W  = 18;
	localparam int SUM_W   = 32;
	localparam int GAIN_W  = 16;
	localparam int LIM_W   = 15;
	localparam int AGAIN_W = 16;
	localparam int ANGLE_W = 8;
	localparam int ACC_W   = 50;
	localparam int MAG_W   = LIM_W + 12;
	localparam int DEG_W   = 11;
	localparam int BITC_W  = 4;
	localparam int CIDX_W  = 3;

	localparam logic [CIDX_W-1:0] REG_KP    = 3'd0;
	localparam logic [CIDX_W-1:0] REG_KI    = 3'd1;
	localparam logic [CIDX_W-1:0] REG_KD    = 3'd2;
	localparam logic [CIDX_W-1:0] REG_LIMIT = 3'd3;
	localparam logic [CIDX_W-1:0] REG_AGAIN = 3'd4;

	localparam logic signed [GAIN_W-1:0] KP_RESET    = 16'sd2048;
	localparam logic signed [GAIN_W-1:0] KI_RESET    = 16'sd0;
	localparam logic signed [GAIN_W-1:0] KD_RESET    = 16'sd410;
	localparam logic [LIM_W-1:0]         LIMIT_RESET = 15'd3840;
	localparam logic [AGAIN_W-1:0]       AGAIN_RESET = 16'd12288;

	localparam logic [1:0] TERM_P = 2'd0;
	localparam logic [1:0] TERM_I = 2'd1;
	localparam logic [1:0] TERM_D = 2'd2;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_CLAMP = 3'd2;
	localparam logic [2:0] ST_ANG   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	localparam logic [BITC_W-1:0] BIT_LAST = 4'd15;

endpackage
`default_nettype wire

// ===== sv/pid_steering_controller.sv =====
// Top level of the PID steering controller: stream ports, gain registers and
// a bit-serial shift-add multiplier sequencer. Depends on pidsc_pkg.
`default_nettype none
// Each position item yields one steering item. An item is taken while the
// sequencer is idle, then the three gain products are formed by one shared
// shift-add multiplier that consumes one gain bit per cycle, the clamp
// follows, then the angle scaling over the angle gain bits, and the result
// is moved to the output register once that register is free. A new item is
// accepted as soon as the sequencer is idle, even while the previous result
// still waits.
module pid_steering_controller (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [15:0]                 s_tdata,   // [15:0] position
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [7:0]                       m_tdata,   // [7:0] steer_angle
	output logic                             m_tuser,   // [0] clamped
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [pidsc_pkg::CIDX_W-1:0] cfg_index,
	input  wire logic [15:0]                 cfg_data
);

	logic signed [pidsc_pkg::GAIN_W-1:0]  kp_q, ki_q, kd_q;
	logic [pidsc_pkg::LIM_W-1:0]          limit_q;
	logic [pidsc_pkg::AGAIN_W-1:0]        again_q;
	logic signed [pidsc_pkg::SUM_W-1:0]   error_sum_q;
	logic signed [pidsc_pkg::ERR_W-1:0]   previous_error_q;
	logic signed [pidsc_pkg::DIFF_W-1:0]  diff_q;
	logic [2:0]                           state_q;
	logic [1:0]                           term_q;
	logic [pidsc_pkg::BITC_W-1:0]         bit_q;
	logic signed [pidsc_pkg::ACC_W-1:0]   acc_q, x_q;
	logic [pidsc_pkg::GAIN_W-1:0]         g_q;
	logic                                 neg_q, clamped_q;
	logic [7:0]                           angle_q;
	logic                                 tuser_q, tvalid_q;

	logic                                 in_acc;
	logic signed [pidsc_pkg::ERR_W-1:0]   err;
	logic signed [pidsc_pkg::SUM_W:0]     sum_wide;
	logic signed [pidsc_pkg::SUM_W-1:0]   sum_sat;
	logic signed [pidsc_pkg::ACC_W-1:0]   lim_ext, abs_u, next_x;
	logic [pidsc_pkg::GAIN_W-1:0]         next_g;
	logic [pidsc_pkg::DEG_W-1:0]          deg;
	logic [7:0]                           angle_d;
	logic                                 out_free;

	assign s_tready  = (state_q == pidsc_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = s_tvalid && s_tready;
	assign out_free  = !tvalid_q || m_tready;
	assign m_tvalid  = tvalid_q;
	assign m_tdata   = angle_q;
	assign m_tuser   = tuser_q;

	assign err      = -{s_tdata[15], s_tdata};
	assign sum_wide = {error_sum_q[pidsc_pkg::SUM_W-1], error_sum_q} +
		(pidsc_pkg::SUM_W+1)'(err);
	assign lim_ext  = pidsc_pkg::ACC_W'({limit_q, 12'd0});
	assign abs_u    = acc_q[pidsc_pkg::ACC_W-1] ? -acc_q : acc_q;
	assign deg      = acc_q[pidsc_pkg::DEG_W+31:32];

	always_comb begin
		if (sum_wide[pidsc_pkg::SUM_W] != sum_wide[pidsc_pkg::SUM_W-1]) begin
			sum_sat = sum_wide[pidsc_pkg::SUM_W] ? {1'b1, {(pidsc_pkg::SUM_W-1){1'b0}}}
				: {1'b0, {(pidsc_pkg::SUM_W-1){1'b1}}};
		end else begin
			sum_sat = sum_wide[pidsc_pkg::SUM_W-1:0];
		end
	end

	// Operand and gain for the term that follows the current one.
	always_comb begin
		if (term_q == pidsc_pkg::TERM_P) begin
			next_x = pidsc_pkg::ACC_W'(error_sum_q);
			next_g = ki_q;
		end else begin
			next_x = pidsc_pkg::ACC_W'(diff_q);
			next_g = kd_q;
		end
	end

	always_comb begin
		if (neg_q) begin
			angle_d = (deg > 11'd128) ? 8'h80 : 8'(-deg);
		end else begin
			angle_d = (deg > 11'd127) ? 8'h7F : deg[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q    <= pidsc_pkg::KP_RESET;
			ki_q    <= pidsc_pkg::KI_RESET;
			kd_q    <= pidsc_pkg::KD_RESET;
			limit_q <= pidsc_pkg::LIMIT_RESET;
			again_q <= pidsc_pkg::AGAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pidsc_pkg::REG_KP:    kp_q    <= cfg_data;
				pidsc_pkg::REG_KI:    ki_q    <= cfg_data;
				pidsc_pkg::REG_KD:    kd_q    <= cfg_data;
				pidsc_pkg::REG_LIMIT: limit_q <= cfg_data[pidsc_pkg::LIM_W-1:0];
				pidsc_pkg::REG_AGAIN: again_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= pidsc_pkg::ST_IDLE;
			term_q           <= pidsc_pkg::TERM_P;
			bit_q            <= '0;
			error_sum_q      <= '0;
			previous_error_q <= '0;
			diff_q           <= '0;
			x_q              <= '0;
			g_q              <= '0;
			acc_q            <= '0;
			neg_q            <= 1'b0;
			clamped_q        <= 1'b0;
			angle_q          <= '0;
			tuser_q          <= 1'b0;
			tvalid_q         <= 1'b0;
		end else begin
			if (tvalid_q && m_tready && (state_q != pidsc_pkg::ST_DONE)) begin
				tvalid_q <= 1'b0;
			end
			unique case (state_q)
				pidsc_pkg::ST_IDLE: begin
					if (in_acc) begin
						error_sum_q      <= sum_sat;
						previous_error_q <= err;
						diff_q           <= pidsc_pkg::DIFF_W'(err) -
							pidsc_pkg::DIFF_W'(previous_error_q);
						x_q              <= pidsc_pkg::ACC_W'(err);
						g_q              <= kp_q;
						acc_q            <= '0;
						term_q           <= pidsc_pkg::TERM_P;
						bit_q            <= '0;
						state_q          <= pidsc_pkg::ST_MUL;
					end
				end
				pidsc_pkg::ST_MUL: begin
					// The sign bit of a gain has negative weight.
					if (g_q[0]) begin
						acc_q <= (bit_q == pidsc_pkg::BIT_LAST) ? acc_q - x_q : acc_q + x_q;
					end
					bit_q <= bit_q + 1'b1;
					if (bit_q == pidsc_pkg::BIT_LAST) begin
						x_q <= next_x;
						g_q <= next_g;
						if (term_q == pidsc_pkg::TERM_D) begin
							state_q <= pidsc_pkg::ST_CLAMP;
						end else begin
							term_q <= term_q + 1'b1;
						end
					end else begin
						x_q <= x_q <<< 1;
						g_q <= g_q >> 1;
					end
				end
				pidsc_pkg::ST_CLAMP: begin
					if (acc_q > lim_ext) begin
						x_q       <= lim_ext;
						neg_q     <= 1'b0;
						clamped_q <= 1'b1;
					end else if (acc_q < -lim_ext) begin
						x_q       <= lim_ext;
						neg_q     <= (limit_q != '0);
						clamped_q <= 1'b1;
					end else begin
						x_q       <= pidsc_pkg::ACC_W'(abs_u[pidsc_pkg::MAG_W-1:0]);
						neg_q     <= acc_q[pidsc_pkg::ACC_W-1];
						clamped_q <= 1'b0;
					end
					g_q     <= again_q;
					acc_q   <= '0;
					bit_q   <= '0;
					state_q <= pidsc_pkg::ST_ANG;
				end
				pidsc_pkg::ST_ANG: begin
					if (g_q[0]) begin
						acc_q <= acc_q + x_q;
					end
					x_q   <= x_q <<< 1;
					g_q   <= g_q >> 1;
					bit_q <= bit_q + 1'b1;
					if (bit_q == pidsc_pkg::BIT_LAST) begin
						state_q <= pidsc_pkg::ST_DONE;
					end
				end
				pidsc_pkg::ST_DONE: begin
					if (out_free) begin
						angle_q  <= angle_d;
						tuser_q  <= clamped_q;
						tvalid_q <= 1'b1;
						state_q  <= pidsc_pkg::ST_IDLE;
					end
				end
				default: state_q <= pidsc_pkg::ST_IDLE;
			endcase
		end
	end

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == pidsc_pkg::ST_MUL) && (bit_q == '0) &&
			(term_q == pidsc_pkg::TERM_P))
		else $error("sequencer did not start on an accepted item");

	a_term: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pidsc_pkg::ST_MUL) |-> (term_q <= pidsc_pkg::TERM_D))
		else $error("term counter ran past the derivative term");

	a_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pidsc_pkg::ST_DONE) && out_free |=> m_tvalid &&
			(state_q == pidsc_pkg::ST_IDLE))
		else $error("finished item was not presented");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pidsc_pkg::ST_DONE) && m_tvalid && !m_tready |=>
			(state_q == pidsc_pkg::ST_DONE))
		else $error("result left the sequencer while the output was full");

endmodule
`default_nettype wire

// ===== bench/pid_steering_controller_tb.sv =====
// Self-checking bench for pid_steering_controller: random and directed position items,
// gain settings written between phases, results checked against a local predictor.
// Depends on pidsc_pkg and the controller RTL only.
`default_nettype none
module pid_steering_controller_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pidsc_pkg::*;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle;
		logic               clamped;
	} steer_t;

	localparam logic [CIDX_W-1:0] IDX_SPARE_LO = REG_AGAIN + 1'b1;
	localparam logic [CIDX_W-1:0] IDX_SPARE_HI = '1;
	localparam longint SUM_MAX = 64'sh7FFF_FFFF;
	localparam longint SUM_MIN = -SUM_MAX - 1;
	localparam int HOLD_AT      = 40;
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 100;
	localparam int RUN_ITEMS    = 20;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [POS_W-1:0]    s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [ANGLE_W-1:0]  m_tdata;
	logic                m_tuser;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CIDX_W-1:0]   cfg_index = '0;
	logic [15:0]         cfg_data = '0;

	// Predictor copy of the registers and the controller state.
	logic signed [GAIN_W-1:0] kp_q = KP_RESET;
	logic signed [GAIN_W-1:0] ki_q = KI_RESET;
	logic signed [GAIN_W-1:0] kd_q = KD_RESET;
	logic [LIM_W-1:0]         lim_q = LIMIT_RESET;
	logic [AGAIN_W-1:0]       again_q = AGAIN_RESET;
	logic signed [SUM_W-1:0]  err_sum = '0;
	logic signed [ERR_W-1:0]  prev_err = '0;

	logic [POS_W-1:0] position_queue [$];
	steer_t           expected_steer [$];

	int items_total = 0;
	int results_seen = 0;
	int fail_count = 0;
	int clamp_count = 0;
	int writes_done = 0;
	int settings_count = 0;
	int idle_odds = 0;
	int src_gap = 0;
	int sink_gap = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int quiet_cycles = 0;

	pid_steering_controller u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic steer_t predict_steer(input logic [POS_W-1:0] pos_bits);
		longint err, diff, acc, u, lim, corr, deg;
		steer_t r;
		err = -longint'($signed(pos_bits));
		diff = err - longint'(prev_err);
		acc = longint'(err_sum) + err;
		if (acc > SUM_MAX)
			acc = SUM_MAX;
		else if (acc < SUM_MIN)
			acc = SUM_MIN;
		err_sum = acc[SUM_W-1:0];
		prev_err = err[ERR_W-1:0];
		u = longint'(kp_q) * err + longint'(ki_q) * acc + longint'(kd_q) * diff;
		lim = longint'(lim_q) <<< 12;
		r.clamped = (u > lim) || (u < -lim);
		corr = (u > lim) ? lim : ((u < -lim) ? -lim : u);
		deg = ((corr < 0 ? -corr : corr) * longint'(again_q)) >>> 32;
		if (corr < 0)
			r.angle = (deg > 128) ? 8'h80 : ANGLE_W'(-deg);
		else
			r.angle = (deg > 127) ? 8'h7F : ANGLE_W'(deg);
		return r;
	endfunction

	function automatic void flag_fault(input string msg);
		fail_count++;
		$display("%0t: %s", $time, msg);
	endfunction

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(0, 6))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3, 4: return 16'(int'($urandom_range(0, 8192)) - 4096);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_limit();
		case ($urandom_range(0, 6))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h7FFF;
			3, 4: return 16'($urandom_range(256, 8192)) | (16'($urandom) & 16'h8000);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_angle_gain();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2, 3: return 16'($urandom_range(2048, 20480));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [POS_W-1:0] pick_position();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h8001;
			3, 4, 5: return 16'(int'($urandom_range(0, 4096)) - 2048);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void queue_position(input logic [POS_W-1:0] pos);
		position_queue.push_back(pos);
		items_total++;
	endfunction

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [15:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_KP:    kp_q = val;
			REG_KI:    ki_q = val;
			REG_KD:    kd_q = val;
			REG_LIMIT: lim_q = val[LIM_W-1:0];
			REG_AGAIN: again_q = val;
			default: ;
		endcase
		writes_done++;
	endtask

	task automatic program_regs(input logic [15:0] kp, ki, kd, lim, ag);
		write_reg(REG_KP, kp);
		write_reg(REG_KI, ki);
		write_reg(REG_KD, kd);
		write_reg(REG_LIMIT, lim);
		write_reg(REG_AGAIN, ag);
		write_reg(CIDX_W'($urandom_range(IDX_SPARE_LO, IDX_SPARE_HI)), 16'($urandom));
		cfg_valid <= 1'b0;
		settings_count++;
	endtask

	task automatic await_results();
		while (results_seen < items_total)
			@(posedge clk);
	endtask

	// Position items go out from the queue, with random gaps before them.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			src_gap = 0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid)
				expected_steer.push_back(predict_steer(s_tdata));
			if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (position_queue.size() > 0 && idle_odds > 0
					&& $urandom_range(1, idle_odds) == 1) begin
				src_gap = $urandom_range(0, 8);
				s_tvalid <= 1'b0;
			end else if (position_queue.size() > 0) begin
				s_tdata <= position_queue.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Steering items are checked here; the receiver also stalls, once for a long stretch.
	always @(posedge clk or negedge arst_n) begin
		steer_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap = 0;
			hold_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_steer.size() == 0) begin
					flag_fault($sformatf("unexpected item: angle %0d clamped %0b",
						$signed(m_tdata), m_tuser));
				end else begin
					want = expected_steer.pop_front();
					if (m_tdata !== want.angle)
						flag_fault($sformatf("steer_angle expected %0d, actual %0d",
							$signed(want.angle), $signed(m_tdata)));
					if (m_tuser !== want.clamped)
						flag_fault($sformatf("clamped expected %0b, actual %0b",
							want.clamped, m_tuser));
					if (want.clamped)
						clamp_count++;
				end
				results_seen++;
			end
			if (results_seen == HOLD_AT && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else if (idle_odds > 0 && $urandom_range(1, idle_odds) == 1) begin
				sink_gap = $urandom_range(0, 8);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		logic [POS_W-1:0] reset_set [10];
		int odds_per_phase [6];

		reset_set = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF,
			16'h8001, 16'h8000, 16'h5555, 16'hAAAA, 16'h0100, 16'hFF00};
		odds_per_phase = '{4, 10, 0, 3, 6, 0};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values of all registers, extremes of the position.
		idle_odds = 4;
		foreach (reset_set[i])
			queue_position(reset_set[i]);
		await_results();

		// Unit proportional gain: a correction exactly at the limit is not clamped.
		program_regs(16'h1000, 16'h0000, 16'h0000, 16'd3840, 16'h1000);
		queue_position(-16'sd3840);
		queue_position(-16'sd3841);
		queue_position(16'sd3840);
		queue_position(16'sd3841);
		await_results();

		// Zero limit.
		program_regs(16'h1000, 16'h0000, 16'h0000, 16'h0000, 16'h1000);
		queue_position(16'h0000);
		queue_position(16'sd5);
		queue_position(-16'sd5);
		await_results();

		// All registers at their extremes, driving the angle into saturation.
		program_regs(16'h7FFF, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF);
		queue_position(16'h7FFF);
		queue_position(16'h8001);
		queue_position(16'h8000);
		queue_position(16'h0000);
		await_results();

		foreach (odds_per_phase[p]) begin
			program_regs(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_angle_gain());
			idle_odds = odds_per_phase[p];
			repeat (76)
				queue_position(pick_position());
			await_results();
		end

		// A run of the most negative position builds up the error sum under a pure
		// integral gain, then the opposite sign walks it back down.
		program_regs(16'h0000, 16'h0001, 16'h0000, 16'h7FFF, 16'hFFFF);
		repeat (RUN_ITEMS)
			queue_position(16'h8000);
		repeat (4)
			queue_position(16'h7FFF);
		await_results();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_steer.size() != 0)
			flag_fault($sformatf("%0d steering items never arrived", expected_steer.size()));
		$display("Covered %0d position items (%0d clamped) under %0d register settings,",
			items_total, clamp_count, settings_count);
		$display("%0d register writes, a long receiver stall and a growing error sum.",
			writes_done);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
sv/pidsc_pkg.sv
sv/pid_steering_controller.sv
bench/pid_steering_controller_tb.sv
